### rtl/crop_nearest_neighbor_downscaler_defines.svh
// Assertion helpers for the crop and nearest-neighbour downscaler.
`ifndef CROP_NEAREST_NEIGHBOR_DOWNSCALER_DEFINES_SVH
`define CROP_NEAREST_NEIGHBOR_DOWNSCALER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CNND_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CNND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cnnd_pkg.sv
package cnnd_pkg;

  // Field widths fixed by the interface
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 16;
  localparam int COORD_W   = 12;
  // Accumulators hold products of two dimensions
  localparam int ACC_W     = 2 * CFG_W;

  // Register reset values (before saturation to the maximum dimension)
  localparam int LINE_WIDTH_RST  = 1800;
  localparam int KEEP_WIDTH_RST  = 1665;
  localparam int KEEP_HEIGHT_RST = 368;
  localparam int OUT_WIDTH_RST   = 800;
  localparam int OUT_HEIGHT_RST  = 170;

  typedef logic [CFG_W-1:0]   cnnd_dim_t;
  typedef logic [ACC_W-1:0]   cnnd_acc_t;
  typedef logic [PIX_W-1:0]   cnnd_pix_t;
  typedef logic [COORD_W-1:0] cnnd_coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH  = 3'd0,
    REG_KEEP_WIDTH  = 3'd1,
    REG_KEEP_HEIGHT = 3'd2,
    REG_OUT_WIDTH   = 3'd3,
    REG_OUT_HEIGHT  = 3'd4
  } cnnd_reg_idx_t;

  typedef struct packed {
    cnnd_dim_t line_width;
    cnnd_dim_t keep_width;
    cnnd_dim_t keep_height;
    cnnd_dim_t out_width;
    cnnd_dim_t out_height;
  } cnnd_cfg_t;

  typedef struct packed {
    cnnd_pix_t   pixel;
    cnnd_coord_t x;
    cnnd_coord_t y;
    logic        last;
  } cnnd_res_t;

endpackage

### rtl/crop_nearest_neighbor_downscaler.sv
// Crop and nearest-neighbour downscaler for a raster stream of RGB565 pixels.
// Input channel (in_valid/in_ready): one source pixel per item, with
// in_frame_start set on the first pixel of a frame to clear all counters.
// Output channel (out_valid/out_ready): one selected pixel with its output
// column, row and a frame_last mark; source pixels outside the crop or not
// picked by the resampling give no output item.
// Configuration channel (cfg_valid/cfg_ready, always ready): register index
// 0..4 = line width, keep width, keep height, out width, out height. Values
// above MAX_DIM clip to MAX_DIM. Write only while the block is idle.
// Path: an accepted item is registered in the input register, evaluated and, if
// selected, placed in the output register, from which it can then be taken.
// Throughput: one item per clock while the output is not stalled.
// Reset (rst_n low, synchronous) restores register defaults, clears counters
// and empties both pipeline registers.
// When the receiver stalls, the output holds; one further item waits in the
// input register and in_ready drops until the output drains.
module crop_nearest_neighbor_downscaler #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cnnd_pkg::PIX_W-1:0]     in_pixel_in,
  input  logic                           in_frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cnnd_pkg::PIX_W-1:0]     out_pixel_out,
  output logic [cnnd_pkg::COORD_W-1:0]   out_x,
  output logic [cnnd_pkg::COORD_W-1:0]   out_y,
  output logic                           out_frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cnnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cnnd_pkg::CFG_W-1:0]     cfg_data
);
  import cnnd_pkg::*;

`include "crop_nearest_neighbor_downscaler_defines.svh"

  cnnd_cfg_t cfg;
  cnnd_res_t sel_res;
  cnnd_res_t out_res;
  logic      hit;
  logic      advance;

  // Input register stage
  logic      s1_valid_r;
  cnnd_pix_t s1_pixel_r;
  logic      s1_start_r;

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pixel_r <= in_pixel_in;
      s1_start_r <= in_frame_start;
    end
  end

  cnnd_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cnnd_select u_sel (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .pixel       (s1_pixel_r),
    .frame_start (s1_start_r),
    .cfg         (cfg),
    .hit         (hit),
    .res         (sel_res)
  );

  cnnd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && hit),
    .res_in    (sel_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_pixel_out  = out_res.pixel;
  assign out_x          = out_res.x;
  assign out_y          = out_res.y;
  assign out_frame_last = out_res.last;

  // A selected pixel always reaches the output register
  `CNND_ASSERT_NEXT(a_hit_loads, clk, rst_n, advance && hit, out_valid,
                    "selected pixel did not reach the output")
  // A held item and a stalled output leave no room for another
  `CNND_ASSERT_NOW(a_full_stall, clk, rst_n, s1_valid_r && out_valid && !out_ready,
                   !in_ready, "input accepted while both stages are full")
  // The end-of-frame pixel sits in the last output column
  `CNND_ASSERT_NOW(a_last_col, clk, rst_n, out_valid && out_frame_last,
                   out_x == cfg.out_width[COORD_W-1:0] - 1'b1,
                   "frame_last off the last output column")

endmodule

### rtl/cnnd_cfg_regs.sv
module cnnd_cfg_regs #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cnnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cnnd_pkg::CFG_W-1:0]     cfg_data,
  output cnnd_pkg::cnnd_cfg_t            cfg
);
  import cnnd_pkg::*;

  // Reset values clipped to the largest supported dimension
  localparam cnnd_dim_t LW_RST = (LINE_WIDTH_RST > MAX_DIM) ? CFG_W'(MAX_DIM)
                                                            : CFG_W'(LINE_WIDTH_RST);
  localparam cnnd_dim_t KW_RST = (KEEP_WIDTH_RST > MAX_DIM) ? CFG_W'(MAX_DIM)
                                                            : CFG_W'(KEEP_WIDTH_RST);
  localparam cnnd_dim_t KH_RST = (KEEP_HEIGHT_RST > MAX_DIM) ? CFG_W'(MAX_DIM)
                                                             : CFG_W'(KEEP_HEIGHT_RST);
  localparam cnnd_dim_t OW_RST = (OUT_WIDTH_RST > MAX_DIM) ? CFG_W'(MAX_DIM)
                                                           : CFG_W'(OUT_WIDTH_RST);
  localparam cnnd_dim_t OH_RST = (OUT_HEIGHT_RST > MAX_DIM) ? CFG_W'(MAX_DIM)
                                                            : CFG_W'(OUT_HEIGHT_RST);

  cnnd_cfg_t cfg_r;
  cnnd_cfg_t cfg_nxt;
  cnnd_dim_t sat_val;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Oversized writes clip to the maximum dimension
  assign sat_val = (32'(cfg_data) > MAX_DIM) ? CFG_W'(MAX_DIM) : cfg_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cnnd_reg_idx_t'(cfg_index))
        REG_LINE_WIDTH:  cfg_nxt.line_width  = sat_val;
        REG_KEEP_WIDTH:  cfg_nxt.keep_width  = sat_val;
        REG_KEEP_HEIGHT: cfg_nxt.keep_height = sat_val;
        REG_OUT_WIDTH:   cfg_nxt.out_width   = sat_val;
        REG_OUT_HEIGHT:  cfg_nxt.out_height  = sat_val;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width  <= LW_RST;
      cfg_r.keep_width  <= KW_RST;
      cfg_r.keep_height <= KH_RST;
      cfg_r.out_width   <= OW_RST;
      cfg_r.out_height  <= OH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/cnnd_select.sv
module cnnd_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  cnnd_pkg::cnnd_pix_t pixel,
  input  logic                frame_start,
  input  cnnd_pkg::cnnd_cfg_t cfg,
  output logic                hit,
  output cnnd_pkg::cnnd_res_t res
);
  import cnnd_pkg::*;

  cnnd_dim_t src_col_r, src_col_nxt;
  cnnd_dim_t src_row_r, src_row_nxt;
  cnnd_dim_t dst_col_r, dst_col_nxt;
  cnnd_dim_t dst_row_r, dst_row_nxt;
  cnnd_acc_t col_need_r, col_need_nxt;
  cnnd_acc_t col_have_r, col_have_nxt;
  cnnd_acc_t row_need_r, row_need_nxt;
  cnnd_acc_t row_have_r, row_have_nxt;

  // Current state, cleared by a frame start
  cnnd_dim_t sc, sr, dc, dr;
  cnnd_acc_t cn, ch, rn, rh;
  logic      row_sel, col_sel, row_end;

  always_comb begin
    sc = frame_start ? '0 : src_col_r;
    sr = frame_start ? '0 : src_row_r;
    dc = frame_start ? '0 : dst_col_r;
    dr = frame_start ? '0 : dst_row_r;
    cn = frame_start ? '0 : col_need_r;
    ch = frame_start ? '0 : col_have_r;
    rn = frame_start ? '0 : row_need_r;
    rh = frame_start ? '0 : row_have_r;
  end

  // Row and column selection by accumulator comparison
  assign row_sel = (sr < cfg.keep_height) && (dr < cfg.out_height) &&
                   ({1'b0, rn} < ({1'b0, rh} + (ACC_W+1)'(cfg.out_height)));
  assign col_sel = (sc < cfg.keep_width) && (dc < cfg.out_width) &&
                   ({1'b0, cn} < ({1'b0, ch} + (ACC_W+1)'(cfg.out_width)));
  assign hit     = row_sel && col_sel;
  assign row_end = ({1'b0, sc} + 1'b1) >= {1'b0, cfg.line_width};

  // Result payload
  always_comb begin
    res.pixel = pixel;
    res.x     = dc[COORD_W-1:0];
    res.y     = dr[COORD_W-1:0];
    res.last  = (({1'b0, dc} + 1'b1) == {1'b0, cfg.out_width}) &&
                (({1'b0, dr} + 1'b1) == {1'b0, cfg.out_height});
  end

  // Counter and accumulator update
  always_comb begin
    src_col_nxt  = sc + 1'b1;
    src_row_nxt  = sr;
    dst_col_nxt  = hit ? dc + 1'b1 : dc;
    dst_row_nxt  = dr;
    col_need_nxt = hit ? cn + ACC_W'(cfg.keep_width) : cn;
    col_have_nxt = ch + ACC_W'(cfg.out_width);
    row_need_nxt = rn;
    row_have_nxt = rh;
    if (row_end) begin
      src_col_nxt  = '0;
      dst_col_nxt  = '0;
      col_need_nxt = '0;
      col_have_nxt = '0;
      if (row_sel) begin
        dst_row_nxt  = dr + 1'b1;
        row_need_nxt = rn + ACC_W'(cfg.keep_height);
      end
      // rows past the kept height are dropped
      if (sr < cfg.keep_height) begin
        src_row_nxt  = sr + 1'b1;
        row_have_nxt = rh + ACC_W'(cfg.out_height);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r  <= '0;
      src_row_r  <= '0;
      dst_col_r  <= '0;
      dst_row_r  <= '0;
      col_need_r <= '0;
      col_have_r <= '0;
      row_need_r <= '0;
      row_have_r <= '0;
    end else if (advance) begin
      src_col_r  <= src_col_nxt;
      src_row_r  <= src_row_nxt;
      dst_col_r  <= dst_col_nxt;
      dst_row_r  <= dst_row_nxt;
      col_need_r <= col_need_nxt;
      col_have_r <= col_have_nxt;
      row_need_r <= row_need_nxt;
      row_have_r <= row_have_nxt;
    end
  end

endmodule

### rtl/cnnd_out_reg.sv
module cnnd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  cnnd_pkg::cnnd_res_t res_in,
  input  logic                out_ready,
  output logic                out_valid,
  output cnnd_pkg::cnnd_res_t res_out
);
  import cnnd_pkg::*;

  logic      valid_r, valid_nxt;
  cnnd_res_t res_r;

  assign out_valid = valid_r;
  assign res_out   = res_r;

  // Holds until taken; a new item may load as the old one leaves
  always_comb begin
    priority if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

### tb/tb_crop_nearest_neighbor_downscaler.sv
module tb_crop_nearest_neighbor_downscaler;
  import cnnd_pkg::*;

  localparam int MAX_DIM       = 4096;
  localparam int DRAIN_CYCLES  = 6;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 600;
  localparam int REPORT_LIMIT  = 10;
  // index past the register map, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  cnnd_pix_t            in_pixel_in;
  logic                 in_frame_start;
  logic                 out_valid;
  logic                 out_ready;
  cnnd_pix_t            out_pixel_out;
  cnnd_coord_t          out_x;
  cnnd_coord_t          out_y;
  logic                 out_frame_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  cnnd_dim_t            cfg_data;

  crop_nearest_neighbor_downscaler #(.MAX_DIM(MAX_DIM)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers
  cnnd_dim_t line_w, keep_w, keep_h, scaled_w, scaled_h;
  // Predictor copy of the raster counters and accumulators
  cnnd_coord_t src_x;
  cnnd_dim_t   src_y, dst_x, dst_y;
  cnnd_acc_t   x_need, x_have, y_need, y_have;

  cnnd_res_t expected_pixels[$];

  int  pixels_sent     = 0;
  int  frames_sent     = 0;
  int  reg_writes      = 0;
  int  results_checked = 0;
  int  mismatches      = 0;
  int  quiet_cycles    = 0;
  int  hold_requests   = 0;
  int  holds_done      = 0;
  bit  idle_on         = 1'b1;

  function automatic cnnd_dim_t clip_dim(input cnnd_dim_t v);
    return (v > MAX_DIM) ? cnnd_dim_t'(MAX_DIM) : v;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Size up to limit; now and then zero or above the limit
  function automatic int pick_size(input int limit);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return limit + $urandom_range(1, 2);
    return $urandom_range(1, (limit < 1) ? 1 : limit);
  endfunction

  task automatic clear_counters();
    src_x  = '0;
    src_y  = '0;
    dst_x  = '0;
    dst_y  = '0;
    x_need = '0;
    x_have = '0;
    y_need = '0;
    y_have = '0;
  endtask

  // Work out the output, if any, of one accepted source pixel
  task automatic predict_pixel(input cnnd_pix_t pix, input logic fs);
    logic      row_pick, col_pick;
    cnnd_res_t res;
    if (fs) clear_counters();
    row_pick = (src_y < keep_h) && (dst_y < scaled_h) && (y_need < y_have + scaled_h);
    col_pick = (src_x < keep_w) && (dst_x < scaled_w) && (x_need < x_have + scaled_w);
    if (row_pick && col_pick) begin
      res.pixel = pix;
      res.x     = dst_x[COORD_W-1:0];
      res.y     = dst_y[COORD_W-1:0];
      res.last  = (dst_x + 1 == scaled_w) && (dst_y + 1 == scaled_h);
      expected_pixels.push_back(res);
      dst_x  = dst_x + 1'b1;
      x_need = x_need + keep_w;
    end
    if (src_x + 1 >= line_w) begin
      // end of source row
      if (row_pick) begin
        dst_y  = dst_y + 1'b1;
        y_need = y_need + keep_h;
      end
      if (src_y < keep_h) begin
        src_y  = src_y + 1'b1;
        y_have = y_have + scaled_h;
      end
      src_x  = '0;
      dst_x  = '0;
      x_need = '0;
      x_have = '0;
    end else begin
      src_x  = src_x + 1'b1;
      x_have = x_have + scaled_w;
    end
  endtask

  // One source pixel; valid is left high for a back-to-back follower
  task automatic send_pixel(input cnnd_pix_t pix, input logic fs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_in    <= pix;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(pix, fs);
    pixels_sent++;
  endtask

  // Register write; caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cnnd_dim_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LINE_WIDTH:  line_w   = clip_dim(val);
      REG_KEEP_WIDTH:  keep_w   = clip_dim(val);
      REG_KEEP_HEIGHT: keep_h   = clip_dim(val);
      REG_OUT_WIDTH:   scaled_w = clip_dim(val);
      REG_OUT_HEIGHT:  scaled_h = clip_dim(val);
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_dims(input int lw, input int kw, input int kh, input int ow,
                          input int oh);
    write_reg(REG_LINE_WIDTH, cnnd_dim_t'(lw));
    write_reg(REG_KEEP_WIDTH, cnnd_dim_t'(kw));
    write_reg(REG_KEEP_HEIGHT, cnnd_dim_t'(kh));
    write_reg(REG_OUT_WIDTH, cnnd_dim_t'(ow));
    write_reg(REG_OUT_HEIGHT, cnnd_dim_t'(oh));
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every expected pixel, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Whole frame with random content, sometimes cut short, plus stray pixels
  task automatic send_frame(input int rows, input bit with_start);
    int per_row, total, cut, extra;
    per_row = (line_w == 0) ? 1 : int'(line_w);
    total   = per_row * rows;
    cut     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
    extra   = $urandom_range(0, 3);
    for (int i = 0; i < cut; i++)
      send_pixel(cnnd_pix_t'($urandom()), with_start && i == 0);
    for (int i = 0; i < extra; i++)
      send_pixel(cnnd_pix_t'($urandom()), $urandom_range(0, 15) == 0);
    frames_sent++;
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
  endtask

  // Default sizes straight out of reset
  task automatic test_reset_defaults();
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hA5A5, 1'b0);
    send_pixel(16'h5A5A, 1'b0);
    settle();
  endtask

  // Zero line width, oversized values, maximum size, unused index, zero keep
  task automatic test_register_limits();
    write_reg(REG_LINE_WIDTH, '0);
    write_reg(REG_KEEP_WIDTH, '1);
    write_reg(REG_KEEP_HEIGHT, cnnd_dim_t'(5000));
    write_reg(REG_OUT_WIDTH, cnnd_dim_t'(MAX_DIM));
    write_reg(REG_OUT_HEIGHT, cnnd_dim_t'(1));
    write_reg(REG_UNUSED, cnnd_dim_t'(1));
    cfg_valid <= 1'b0;
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    settle();
    write_reg(REG_KEEP_WIDTH, '0);
    cfg_valid <= 1'b0;
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0001, 1'b0);
    settle();
  endtask

  // Small complete frame with frame_last, then rows past the kept height
  task automatic test_small_frame();
    set_dims(3, 3, 2, 2, 2);
    for (int i = 0; i < 8; i++)
      send_pixel((i % 2) ? 16'hFFFF : 16'h0000, i == 0);
    settle();
  endtask

  // Keep width above line width, output taller than kept, restart mid-row
  task automatic test_upscale_request();
    set_dims(2, 4, 2, 3, 3);
    send_pixel(16'h8001, 1'b1);
    send_pixel(16'h7FFE, 1'b0);
    send_pixel(16'hC3C3, 1'b0);
    send_pixel(16'h3C3C, 1'b1);
    send_pixel(16'hF00F, 1'b0);
    settle();
  endtask

  // Receiver holds off for a long stretch while every pixel is selected
  task automatic test_backpressure();
    set_dims(8, 8, 8, 8, 8);
    idle_on = 1'b0;
    hold_requests++;
    send_frame(8, 1'b1);
    settle();
    idle_on = 1'b1;
  endtask

  // Random sizes per phase, frames with random content and stray pixels
  task automatic test_random_frames();
    int goal, lw, kw, kh, nframes;
    goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < goal) begin
      lw = pick_size(10);
      kw = pick_size(lw);
      kh = pick_size(5);
      set_dims(lw, kw, kh, pick_size(kw), pick_size(kh));
      idle_on = ($urandom_range(0, 3) != 0);
      nframes = $urandom_range(1, 3);
      // the first frame sometimes carries on from the previous counters
      for (int f = 0; f < nframes; f++)
        send_frame(((kh == 0) ? 1 : kh) + $urandom_range(0, 2),
                   f != 0 || $urandom_range(0, 6) != 0);
      settle();
    end
    idle_on = 1'b1;
  endtask

  // Receiver: random stalls, plus a long hold when one is requested
  initial begin : receiver
    int pause, run;
    out_ready = 1'b0;
    forever begin
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        pause = pick_gap();
        if (pause > 0) begin
          out_ready <= 1'b0;
          repeat (pause) @(posedge clk);
        end
        out_ready <= 1'b1;
        run = $urandom_range(1, 12);
        repeat (run) @(posedge clk);
      end
    end
  end

  // Compare each output item with the oldest expected pixel
  always @(posedge clk) begin : check_outputs
    cnnd_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel %h x %0d y %0d last %b",
                                out_pixel_out, out_x, out_y, out_frame_last));
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (out_pixel_out !== want.pixel || out_x !== want.x || out_y !== want.y ||
            out_frame_last !== want.last)
          note_mismatch($sformatf(
            "expected pixel %h x %0d y %0d last %b, got pixel %h x %0d y %0d last %b",
            want.pixel, want.x, want.y, want.last,
            out_pixel_out, out_x, out_y, out_frame_last));
      end
    end
  end

  // Watchdog: too long without any handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_in    = '0;
    in_frame_start = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_LINE_WIDTH;
    cfg_data       = '0;
    line_w   = clip_dim(cnnd_dim_t'(LINE_WIDTH_RST));
    keep_w   = clip_dim(cnnd_dim_t'(KEEP_WIDTH_RST));
    keep_h   = clip_dim(cnnd_dim_t'(KEEP_HEIGHT_RST));
    scaled_w = clip_dim(cnnd_dim_t'(OUT_WIDTH_RST));
    scaled_h = clip_dim(cnnd_dim_t'(OUT_HEIGHT_RST));
    clear_counters();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_limits();
    test_small_frame();
    test_upscale_request();
    test_backpressure();
    test_random_frames();

    $display("Sent %0d source pixels in %0d random frames with %0d register writes,",
             pixels_sent, frames_sent, reg_writes);
    $display("including crop limits, upscale requests and a long output stall; %0d %s",
             results_checked, "output pixels checked.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### crop_nearest_neighbor_downscaler.f
+incdir+rtl
rtl/cnnd_pkg.sv
rtl/cnnd_cfg_regs.sv
rtl/cnnd_select.sv
rtl/cnnd_out_reg.sv
rtl/crop_nearest_neighbor_downscaler.sv
tb/tb_crop_nearest_neighbor_downscaler.sv
